/* design/cle_pkg.sv */
// Shared constants and types for the console line editor.
package cle_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CFG_W     = 9;
  localparam int DEPTH_W   = $clog2(BUF_DEPTH + 1);
  localparam int CMP_W     = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
  localparam int CHAR_W    = 7;

  localparam logic [CMP_W-1:0] DEPTH_C      = CMP_W'(BUF_DEPTH);
  localparam logic [CFG_W-1:0] SIZE_RESET   = 9'd256;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_BELL = 8'h07;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_KILL = 8'h15;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] len;
  } slot_t;

endpackage

/* design/cle_ram.sv */
// Generic single-port RAM with registered read.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/console_line_editor.sv */
// Console line editor top level: echo, line editing and line store readback.
//
// Each accepted beat produces one to three result beats, one per cycle while
// out_stall is low; the next input beat is taken in the cycle the previous
// item's last result leaves. The line store is one single-port RAM of
// cle_pkg::BUF_DEPTH 7-bit entries, written or read at most once per item when
// the item is accepted; read data is returned in the next cycle as the item's
// only result. Per-entry valid flops make unwritten entries read as zero right
// after reset, so there is no clearing pass. The buffer_size register (reset
// 256) may be written whenever no item is in flight; cfg_ready is always high.
module console_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_line_length,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_buffer_size
);

  logic [cle_pkg::CFG_W-1:0]  size_r;
  logic [7:0]                 pos_r, pos_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  cle_pkg::slot_t             slot0_r, slot1_r, slot2_r;
  cle_pkg::slot_t             slot0_nxt, slot1_nxt, slot2_nxt;
  logic                       rd_r, rd_ok_r, rd_vld_r;
  logic [cle_pkg::BUF_DEPTH-1:0] vld_r;

  logic                       acc, take;
  logic [cle_pkg::CMP_W-1:0]  sz, cap_w;
  logic [7:0]                 cap;
  logic                       pos_ok, ridx_ok;
  logic [6:0]                 c7;
  logic                       wr;
  logic [6:0]                 wr_data;
  logic [cle_pkg::ADDR_W-1:0] ram_addr, pos_addr, ridx_addr;
  logic [cle_pkg::CHAR_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall));
  assign acc       = in_valid && !in_stall;

  always_comb begin
    sz      = (cle_pkg::CMP_W'(size_r) > cle_pkg::DEPTH_C) ?
              cle_pkg::DEPTH_C : cle_pkg::CMP_W'(size_r);
    cap_w   = (sz == '0) ? '0 : sz - cle_pkg::CMP_W'(1);
    cap     = (cap_w > cle_pkg::CMP_W'(255)) ? 8'hFF : cap_w[7:0];
    pos_ok  = cle_pkg::CMP_W'(pos_r) < cle_pkg::DEPTH_C;
    ridx_ok = cle_pkg::CMP_W'(in_read_index) < cle_pkg::DEPTH_C;
  end

  assign pos_addr  = cle_pkg::ADDR_W'(pos_r);
  assign ridx_addr = cle_pkg::ADDR_W'(in_read_index);
  assign c7        = in_rx_byte[6:0];

  always_comb begin
    slot0_nxt = '{kind: cle_pkg::KIND_ECHO, data: in_rx_byte, len: 8'd0};
    slot1_nxt = '{kind: cle_pkg::KIND_ECHO, data: 8'd0, len: 8'd0};
    slot2_nxt = '{kind: cle_pkg::KIND_ECHO, data: 8'd0, len: 8'd0};
    cnt_nxt   = 2'd1;
    pos_nxt   = pos_r;
    wr        = 1'b0;
    wr_data   = 7'd0;
    if (in_operation == cle_pkg::OP_READ) begin
      slot0_nxt = '{kind: cle_pkg::KIND_READ, data: 8'd0, len: 8'd0};
    end else if (in_rx_byte == cle_pkg::CH_CR) begin
      slot0_nxt.data = cle_pkg::CH_CR;
      slot1_nxt.data = cle_pkg::CH_LF;
      slot2_nxt      = '{kind: cle_pkg::KIND_LINE, data: 8'd0, len: pos_r};
      cnt_nxt        = 2'd3;
      wr             = pos_ok;
      pos_nxt        = 8'd0;
    end else if (in_rx_byte == cle_pkg::CH_DEL || in_rx_byte == cle_pkg::CH_BS) begin
      slot0_nxt.data = cle_pkg::CH_BS;
      slot1_nxt.data = cle_pkg::CH_SP;
      slot2_nxt.data = cle_pkg::CH_BS;
      cnt_nxt        = 2'd3;
      if (pos_r != 8'd0) begin
        pos_nxt = pos_r - 8'd1;
      end
    end else begin
      unique case ({1'b0, c7})
        cle_pkg::CH_LF, cle_pkg::CH_CR: begin
          slot1_nxt = '{kind: cle_pkg::KIND_LINE, data: 8'd0, len: pos_r};
          cnt_nxt   = 2'd2;
          wr        = pos_ok;
          pos_nxt   = 8'd0;
        end
        cle_pkg::CH_BS: begin
          if (pos_r != 8'd0) begin
            pos_nxt = pos_r - 8'd1;
          end
        end
        cle_pkg::CH_KILL: begin
          slot1_nxt.data = cle_pkg::CH_CR;
          slot2_nxt.data = cle_pkg::CH_LF;
          cnt_nxt        = 2'd3;
          pos_nxt        = 8'd0;
        end
        default: begin
          if (pos_r < cap) begin
            wr      = 1'b1;
            wr_data = c7;
            pos_nxt = pos_r + 8'd1;
          end else begin
            slot1_nxt.data = cle_pkg::CH_BELL;
            cnt_nxt        = 2'd2;
          end
        end
      endcase
    end
  end

  assign ram_addr = (in_operation == cle_pkg::OP_READ) ? ridx_addr : pos_addr;

  cle_ram #(
    .WIDTH(cle_pkg::CHAR_W),
    .DEPTH(cle_pkg::BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (acc && wr),
    .re   (acc && (in_operation == cle_pkg::OP_READ)),
    .addr (ram_addr),
    .wdata(wr_data),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= cle_pkg::SIZE_RESET;
      pos_r  <= 8'd0;
      cnt_r  <= 2'd0;
      vld_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_buffer_size;
      end
      if (acc) begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
        if (wr) begin
          vld_r[pos_addr] <= 1'b1;
        end
      end else if (take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot0_r  <= slot0_nxt;
      slot1_r  <= slot1_nxt;
      slot2_r  <= slot2_nxt;
      rd_r     <= (in_operation == cle_pkg::OP_READ);
      rd_ok_r  <= ridx_ok;
      rd_vld_r <= vld_r[ridx_addr];
    end else if (take) begin
      slot0_r <= slot1_r;
      slot1_r <= slot2_r;
      rd_r    <= 1'b0;
    end
  end

  assign out_result_kind = slot0_r.kind;
  assign out_data_byte   = (rd_r) ? ((rd_ok_r && rd_vld_r) ? {1'b0, ram_rdata} : 8'd0)
                                  : slot0_r.data;
  assign out_line_length = slot0_r.len;
  assign out_last        = (cnt_r == 2'd1);

endmodule

/* design/cle_check.sv */
// Port-level checker for the console line editor, bound to the top level.
module cle_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_operation,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_line_length,
  input logic       out_last
);

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("result burst broken before last beat");

  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == cle_pkg::OP_READ) |=>
      out_valid && out_last && (out_result_kind == cle_pkg::KIND_READ))
    else $error("read item did not give one read beat");

  a_cr_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == cle_pkg::OP_RX) &&
      (in_rx_byte == cle_pkg::CH_CR) |=>
      out_valid && !out_last && (out_data_byte == cle_pkg::CH_CR))
    else $error("carriage return not echoed first");

  a_len_only_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != cle_pkg::KIND_LINE) |-> out_line_length == 8'd0)
    else $error("line length set on non-line beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_result_kind))
    else $error("stalled result beat changed");

endmodule

bind console_line_editor cle_check u_cle_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .in_rx_byte     (in_rx_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_result_kind(out_result_kind),
  .out_data_byte  (out_data_byte),
  .out_line_length(out_line_length),
  .out_last       (out_last)
);
